### rtl/asr_pkg.sv
package asr_pkg;

    // Store depth shared by both sign classes together
    localparam int SET_DEPTH = 64;
    localparam int ADDR_W    = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DRAIN
    } asr_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // store the request on the ports
        logic issue;  // read the next element of the run
        logic clear;  // end of run: reset counts and pointers
    } asr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_issue;  // the read issued now is the final one of the run
    } asr_stat_t;

endpackage

### rtl/asr_ram.sv
module asr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/asr_ctrl.sv
module asr_ctrl
    import asr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      end_of_set,
    input  asr_stat_t stat,
    output asr_cmd_t  cmd,
    output logic      busy
);

    asr_state_t state_reg;
    asr_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance on the last request of a set, then through the run
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && end_of_set)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EMIT:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.clear = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/asr_datapath.sv
module asr_datapath
    import asr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  asr_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] sample_value,
    output asr_stat_t                stat,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     out_last,
    output logic                     truncated
);

    logic [CNT_W-1:0]  nn_cnt_reg, nn_cnt_next;
    logic [CNT_W-1:0]  ng_cnt_reg, ng_cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              take_reg, take_next;
    logic              valid_reg;
    logic              sel_reg;
    logic              last_reg;
    logic              trunc_reg;

    logic [CNT_W-1:0]  total;
    logic              full;
    logic              is_neg;
    logic              nn_we, ng_we;
    logic              use_nn;
    logic [DATA_W-1:0] nn_rdata, ng_rdata;

    assign total  = nn_cnt_reg + ng_cnt_reg;
    assign full   = (total >= CNT_W'(SET_DEPTH));
    assign is_neg = sample_value[DATA_W-1];
    assign nn_we  = cmd.load && !full && !is_neg;
    assign ng_we  = cmd.load && !full && is_neg;

    // Pick the class for this position; fall back when one runs out
    always_comb
    begin
        if (p_reg >= nn_cnt_reg)
        begin
            use_nn = 1'b0;
        end
        else if (q_reg >= ng_cnt_reg)
        begin
            use_nn = 1'b1;
        end
        else
        begin
            use_nn = take_reg;
        end
    end

    assign stat.last_issue = cmd.issue && (k_reg + CNT_W'(1) == total);

    // Update counts, overflow flag and read pointers
    always_comb
    begin
        nn_cnt_next = nn_cnt_reg;
        ng_cnt_next = ng_cnt_reg;
        ovf_next    = ovf_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        take_next   = take_reg;
        if (cmd.clear)
        begin
            nn_cnt_next = '0;
            ng_cnt_next = '0;
            ovf_next    = 1'b0;
            p_next      = '0;
            q_next      = '0;
            k_next      = '0;
            take_next   = 1'b1;
        end
        else if (cmd.issue)
        begin
            if (use_nn)
            begin
                p_next = p_reg + CNT_W'(1);
            end
            else
            begin
                q_next = q_reg + CNT_W'(1);
            end
            k_next    = k_reg + CNT_W'(1);
            take_next = !take_reg;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else if (is_neg)
            begin
                ng_cnt_next = ng_cnt_reg + CNT_W'(1);
            end
            else
            begin
                nn_cnt_next = nn_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nn_cnt_reg <= '0;
            ng_cnt_reg <= '0;
            ovf_reg    <= 1'b0;
            p_reg      <= '0;
            q_reg      <= '0;
            k_reg      <= '0;
            take_reg   <= 1'b1;
            valid_reg  <= 1'b0;
        end
        else
        begin
            nn_cnt_reg <= nn_cnt_next;
            ng_cnt_reg <= ng_cnt_next;
            ovf_reg    <= ovf_next;
            p_reg      <= p_next;
            q_reg      <= q_next;
            k_reg      <= k_next;
            take_reg   <= take_next;
            valid_reg  <= cmd.issue;
        end
    end

    // Track the read in flight alongside the RAM latency
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            sel_reg   <= use_nn;
            last_reg  <= stat.last_issue;
            trunc_reg <= ovf_reg;
        end
    end

    asr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH)
    ) u_nn_ram (
        .clk     (clk),
        .wr_en   (nn_we),
        .wr_addr (nn_cnt_reg[ADDR_W-1:0]),
        .wr_data (sample_value),
        .rd_en   (cmd.issue),
        .rd_addr (p_reg[ADDR_W-1:0]),
        .rd_data (nn_rdata)
    );

    asr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_DEPTH)
    ) u_ng_ram (
        .clk     (clk),
        .wr_en   (ng_we),
        .wr_addr (ng_cnt_reg[ADDR_W-1:0]),
        .wr_data (sample_value),
        .rd_en   (cmd.issue),
        .rd_addr (q_reg[ADDR_W-1:0]),
        .rd_data (ng_rdata)
    );

    assign out_valid = valid_reg;
    assign out_value = sel_reg ? nn_rdata : ng_rdata;
    assign out_last  = last_reg;
    assign truncated = trunc_reg;

endmodule

### rtl/alternate_sign_rearrange.sv
// Loads signed words one per cycle while busy is low (start high accepts a
// request). The request with end_of_set high closes the set; the block then
// raises busy and emits the set reordered as non-negative, negative,
// non-negative, ..., each class in arrival order, zero counted non-negative.
// Results come one per cycle on out_valid from registered store reads, and
// the receiver cannot stall them; out_last marks the final result and
// truncated is high on every result of a set that lost words beyond the
// 64-entry store. Busy stays high through the emit state, which reads one
// word per cycle from the two single-read-port stores, and the drain state.
module alternate_sign_rearrange
    import asr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] sample_value,
    input  logic                     end_of_set,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     out_last,
    output logic                     truncated
);

    asr_cmd_t  cmd;
    asr_stat_t stat;

    asr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .end_of_set (end_of_set),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    asr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_value (sample_value),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .out_last     (out_last),
        .truncated    (truncated)
    );

`ifndef SYNTHESIS
    // Results appear only during a run
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result outside a run");

    // A run is contiguous until its final result
    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |=> out_valid)
        else $error("gap inside a run");

    // Nothing follows the final result directly
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |=> !out_valid)
        else $error("result after final element");

    // Closing request starts a run
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && end_of_set |=> busy)
        else $error("closing request did not start a run");
`endif

endmodule

### tb/rearrange_checker.sv
module rearrange_checker
    import asr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] sample_value,
    input  logic                     end_of_set,
    input  logic                     out_valid,
    input  logic signed [DATA_W-1:0] out_value,
    input  logic                     out_last,
    input  logic                     truncated,
    output int                       mismatch_count,
    output int                       pending_results
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     trunc;
    } run_word_t;

    // Shadow copy of the two sign-class stores and their fill levels
    logic signed [DATA_W-1:0] nonneg_words [SET_DEPTH];
    logic signed [DATA_W-1:0] neg_words    [SET_DEPTH];
    int                       nonneg_held;
    int                       neg_held;
    logic                     words_dropped;
    run_word_t                expected_run [$];

    initial
    begin
        mismatch_count  = 0;
        pending_results = 0;
        nonneg_held     = 0;
        neg_held        = 0;
        words_dropped   = 1'b0;
    end

    // Report the first ten mismatches in full, count the rest
    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (mismatch_count < 10)
        begin
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    // Interleave the stored classes, non-negative first, and queue the run
    task automatic queue_run();
        int        total;
        int        p;
        int        q;
        bit        take_nonneg;
        bit        use_nonneg;
        run_word_t item;
        total       = nonneg_held + neg_held;
        p           = 0;
        q           = 0;
        take_nonneg = 1'b1;
        for (int k = 0; k < total; k++)
        begin
            if (p >= nonneg_held)
                use_nonneg = 1'b0;
            else if (q >= neg_held)
                use_nonneg = 1'b1;
            else
                use_nonneg = take_nonneg;
            if (use_nonneg)
            begin
                item.value = nonneg_words[p];
                p++;
            end
            else
            begin
                item.value = neg_words[q];
                q++;
            end
            take_nonneg = !take_nonneg;
            item.last   = (k + 1 == total);
            item.trunc  = words_dropped;
            expected_run.push_back(item);
        end
        nonneg_held   = 0;
        neg_held      = 0;
        words_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonneg_held   = 0;
            neg_held      = 0;
            words_dropped = 1'b0;
            expected_run.delete();
        end
        else
        begin
            // Compare each emitted word with the oldest expectation
            if (out_valid)
            begin
                if (expected_run.size() == 0)
                begin
                    flag_mismatch("unexpected result value", '0, out_value);
                end
                else
                begin
                    run_word_t want;
                    want = expected_run.pop_front();
                    if (out_value !== want.value)
                        flag_mismatch("out_value", want.value, out_value);
                    if (out_last !== want.last)
                        flag_mismatch("out_last", DATA_W'(want.last), DATA_W'(out_last));
                    if (truncated !== want.trunc)
                        flag_mismatch("truncated", DATA_W'(want.trunc), DATA_W'(truncated));
                end
            end

            // Store an accepted request by sign, drop it once the store is full
            if (start && !busy)
            begin
                if (nonneg_held + neg_held >= SET_DEPTH)
                begin
                    words_dropped = 1'b1;
                end
                else if (sample_value[DATA_W-1])
                begin
                    neg_words[neg_held] = sample_value;
                    neg_held++;
                end
                else
                begin
                    nonneg_words[nonneg_held] = sample_value;
                    nonneg_held++;
                end
                if (end_of_set)
                    queue_run();
            end
        end
        pending_results = expected_run.size();
    end

endmodule

### tb/tb_alternate_sign_rearrange.sv
module tb_alternate_sign_rearrange;
    import asr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SMALL_SET_ITEMS = 4;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] sample_value;
    logic                     end_of_set;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;
    logic                     truncated;

    int mismatch_count;
    int pending_results;
    int idle_pct;
    int quiet_cycles;

    alternate_sign_rearrange uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_value (sample_value),
        .end_of_set   (end_of_set),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .out_last     (out_last),
        .truncated    (truncated)
    );

    rearrange_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample_value    (sample_value),
        .end_of_set      (end_of_set),
        .out_valid       (out_valid),
        .out_value       (out_value),
        .out_last        (out_last),
        .truncated       (truncated),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = ~clk;
    end

    // Abort when neither a request nor a result moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** alternate_sign_rearrange: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Random word, forced into the wanted sign class with a bias toward extremes
    function automatic logic signed [DATA_W-1:0] pick_word(input int neg_pct);
        logic signed [DATA_W-1:0] w;
        logic                     want_neg;
        case ($urandom_range(9))
            0:       w = '0;
            1:       w = {1'b0, {(DATA_W-1){1'b1}}};
            2:       w = {1'b1, {(DATA_W-1){1'b0}}};
            3:       w = '1;
            4, 5:    w = $urandom_range(15);
            default: w = $urandom;
        endcase
        want_neg = ($urandom_range(99) < neg_pct);
        if (w[DATA_W-1] != want_neg)
            w = ~w;
        return w;
    endfunction

    // Present one request, idle first at random, hold it until accepted
    task automatic send_request(input logic signed [DATA_W-1:0] w, input logic closes);
        while ($urandom_range(99) < idle_pct)
        begin
            start        <= 1'b0;
            sample_value <= $urandom;
            end_of_set   <= 1'($urandom_range(1));
            @(negedge clk);
        end
        start        <= 1'b1;
        sample_value <= w;
        end_of_set   <= closes;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_set(input int size, input int neg_pct);
        for (int i = 0; i < size; i++)
            send_request(pick_word(neg_pct), i == size - 1);
    endtask

    // Hold off new requests until every queued result has come out
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
    endtask

    int sender_idle [4] = '{0, 66, 0, 37};

    initial
    begin
        int sent;
        int size;
        int bias;
        start        = 1'b0;
        sample_value = '0;
        end_of_set   = 1'b0;
        idle_pct     = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-word sets of each kind
        send_request(32'sd5, 1'b1);
        send_request(-32'sd7, 1'b1);
        send_request(32'sd0, 1'b1);
        // Extremes of the word range
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(32'sd1, 1'b1);
        // Only negatives, then only non-negatives
        send_request(-32'sd1, 1'b0);
        send_request(-32'sd2, 1'b0);
        send_request(-32'sd3, 1'b1);
        send_request(32'sd0, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(32'sd9, 1'b1);
        // Zero arriving where a negative would stand
        send_request(-32'sd4, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(-32'sd8, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(32'sd6, 1'b1);
        // Non-negatives outnumber negatives, tail follows in order
        send_request(32'sd1, 1'b0);
        send_request(32'sd2, 1'b0);
        send_request(-32'sd3, 1'b0);
        send_request(32'sd4, 1'b1);
        wait_drained();

        // Random sets under each idling profile
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = sender_idle[ph];
            sent     = 0;
            while (sent < SMALL_SET_ITEMS)
            begin
                size = $urandom_range(1, 8);
                case ($urandom_range(3))
                    0:       bias = 0;
                    1:       bias = 100;
                    2:       bias = 50;
                    default: bias = $urandom_range(100);
                endcase
                send_set(size, bias);
                sent += size;
            end
            // Overrun the store so the closing word is dropped
            if (ph == 3)
                send_set(SET_DEPTH + $urandom_range(1, 4), $urandom_range(100));
            wait_drained();
        end

        // Settle past the last result
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("** alternate_sign_rearrange: PASSED **");
        else
            $display("** alternate_sign_rearrange: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/asr_pkg.sv
rtl/asr_ram.sv
rtl/asr_ctrl.sv
rtl/asr_datapath.sv
rtl/alternate_sign_rearrange.sv
tb/rearrange_checker.sv
tb/tb_alternate_sign_rearrange.sv
